// File: rtl/core/mgd_pkg.sv
// ----------------------------------------------------------------------------
// mgd_pkg
// Shared types and constants for the mouse gesture detector.
// ----------------------------------------------------------------------------
package mgd_pkg;

  localparam int BYTE_W      = 8;
  localparam int DELTA_W     = 9;
  localparam int TOTAL_W     = 16;
  localparam int CFG_W       = 16;
  localparam int CFG_INDEX_W = 1;
  localparam int RESULT_W    = 40;

  localparam int DEFAULT_QUEUE_DEPTH = 2;

  localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_LENGTH      = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_VERTICAL_TOLERANCE = 1'd1;

  localparam logic [TOTAL_W-1:0] TARGET_LENGTH_RESET      = 16'd100;
  localparam logic [TOTAL_W-1:0] VERTICAL_TOLERANCE_RESET = 16'd10;

  localparam int SYNC_BIT    = 3;
  localparam int X_SIGN_BIT  = 4;
  localparam int Y_SIGN_BIT  = 5;

  typedef struct packed {
    logic               vert_overflow;
    logic               horiz_overflow;
    logic               middle_button;
    logic               right_button;
    logic               left_button;
    logic [DELTA_W-1:0] delta_y;
    logic [DELTA_W-1:0] delta_x;
  } packet_t;

  typedef struct packed {
    logic               gesture_done;
    logic [TOTAL_W-1:0] travel_sum;
    logic [DELTA_W-1:0] delta_y;
    logic [DELTA_W-1:0] delta_x;
    logic               vert_overflow;
    logic               horiz_overflow;
    logic               middle_button;
    logic               right_button;
    logic               left_button;
  } result_t;

  typedef struct packed {
    logic    valid;
    packet_t packet;
  } queue_port_t;

endpackage

// File: rtl/core/mgd_framer.sv
// ----------------------------------------------------------------------------
// mgd_framer
// Hunts for the sync bit, gathers three bytes and decodes a packet.
// ----------------------------------------------------------------------------
module mgd_framer (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [mgd_pkg::BYTE_W-1:0] s_tdata,   // [7:0] mouse_byte
  input  logic                       queue_full,
  output mgd_pkg::queue_port_t       push
);
  import mgd_pkg::*;

  typedef enum logic [1:0] {
    HUNT,
    GOT_FIRST,
    GOT_SECOND
  } frame_state_t;

  frame_state_t        state;
  logic [BYTE_W-1:0]   first_byte;
  logic [BYTE_W-1:0]   second_byte;
  logic                transfer;

  assign s_tready = (state != GOT_SECOND) || !queue_full;
  assign transfer = s_tvalid && s_tready;

  assign push.valid                 = transfer && (state == GOT_SECOND);
  assign push.packet.left_button    = first_byte[0];
  assign push.packet.right_button   = first_byte[1];
  assign push.packet.middle_button  = first_byte[2];
  assign push.packet.horiz_overflow = first_byte[6];
  assign push.packet.vert_overflow  = first_byte[7];
  assign push.packet.delta_x        = {first_byte[X_SIGN_BIT], second_byte};
  assign push.packet.delta_y        = {first_byte[Y_SIGN_BIT], s_tdata};

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= HUNT;
      first_byte  <= '0;
      second_byte <= '0;
    end else if (transfer) begin
      unique case (state)
        HUNT: begin
          if (s_tdata[SYNC_BIT]) begin
            first_byte <= s_tdata;
            state      <= GOT_FIRST;
          end
        end
        GOT_FIRST: begin
          second_byte <= s_tdata;
          state       <= GOT_SECOND;
        end
        GOT_SECOND: begin
          state <= HUNT;
        end
        default: begin
          state <= HUNT;
        end
      endcase
    end
  end

endmodule

// File: rtl/core/mgd_queue.sv
// ----------------------------------------------------------------------------
// mgd_queue
// Short packet queue between the framer and the gesture tracker.
// ----------------------------------------------------------------------------
module mgd_queue #(
  parameter int DEPTH = mgd_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  mgd_pkg::queue_port_t push,
  output logic                 full,
  output logic                 head_valid,
  output mgd_pkg::packet_t     head,
  input  logic                 pop
);
  import mgd_pkg::*;

  localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COUNT_W = $clog2(DEPTH + 1);

  localparam logic [PTR_W-1:0]   LAST_PTR   = PTR_W'(DEPTH - 1);
  localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(DEPTH);

  packet_t             slots [DEPTH];
  logic [PTR_W-1:0]    wptr;
  logic [PTR_W-1:0]    rptr;
  logic [COUNT_W-1:0]  count;
  logic                do_push;
  logic                do_pop;

  assign full       = (count == FULL_COUNT);
  assign head_valid = (count != '0);
  assign head       = slots[rptr];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= push.packet;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == LAST_PTR) ? '0 : wptr + PTR_W'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == LAST_PTR) ? '0 : rptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + COUNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - COUNT_W'(1);
      end
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    full |-> !push.valid)
    else $error("packet pushed into a full queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("queue count out of range");

endmodule

// File: rtl/core/mgd_tracker.sv
// ----------------------------------------------------------------------------
// mgd_tracker
// Holds the gesture totals, updates them per packet and registers the result.
// ----------------------------------------------------------------------------
module mgd_tracker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [mgd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mgd_pkg::CFG_W-1:0]       cfg_data,
  input  logic                            head_valid,
  input  mgd_pkg::packet_t                head,
  output logic                            pop,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output mgd_pkg::result_t                result
);
  import mgd_pkg::*;

  logic signed [TOTAL_W-1:0] target_length;
  logic        [TOTAL_W-1:0] vertical_tolerance;
  logic signed [TOTAL_W-1:0] hsum;
  logic        [TOTAL_W-1:0] vtot;

  logic signed [DELTA_W-1:0] dx;
  logic signed [DELTA_W-1:0] dy;
  logic        [DELTA_W-1:0] ady;
  logic        [TOTAL_W:0]   vt_wide;
  logic        [TOTAL_W-1:0] vt;
  logic signed [TOTAL_W:0]   s_wide;
  logic signed [TOTAL_W-1:0] s_sat;
  logic signed [TOTAL_W-1:0] s_dir;
  logic signed [TOTAL_W-1:0] tsum;
  logic                      in_gesture;
  logic                      target_pos;
  logic                      done;
  logic                      clear_all;
  logic signed [TOTAL_W-1:0] hsum_next;
  logic        [TOTAL_W-1:0] vtot_next;

  assign pop = head_valid && (!m_tvalid || m_tready);

  always_comb begin
    dx  = head.delta_x;
    dy  = head.delta_y;
    ady = dy[DELTA_W-1] ? DELTA_W'(-dy) : DELTA_W'(dy);

    vt_wide = {1'b0, vtot} + {{(TOTAL_W + 1 - DELTA_W){1'b0}}, ady};
    vt      = vt_wide[TOTAL_W] ? {TOTAL_W{1'b1}} : vt_wide[TOTAL_W-1:0];

    in_gesture = (vt < vertical_tolerance) && head.left_button;

    s_wide = {hsum[TOTAL_W-1], hsum} + {{(TOTAL_W + 1 - DELTA_W){dx[DELTA_W-1]}}, dx};
    if (s_wide[TOTAL_W] != s_wide[TOTAL_W-1]) begin
      s_sat = s_wide[TOTAL_W] ? {1'b1, {(TOTAL_W-1){1'b0}}} : {1'b0, {(TOTAL_W-1){1'b1}}};
    end else begin
      s_sat = s_wide[TOTAL_W-1:0];
    end
    tsum = in_gesture ? s_sat : hsum;

    target_pos = !target_length[TOTAL_W-1] && (target_length != '0);
    if (target_pos) begin
      s_dir = dx[DELTA_W-1] ? '0 : s_sat;
      done  = in_gesture && (s_dir >= target_length);
    end else begin
      s_dir = (!dx[DELTA_W-1] && (dx != '0)) ? '0 : s_sat;
      done  = in_gesture && (s_dir < target_length);
    end

    clear_all = done || (vt > vertical_tolerance) || !head.left_button;
    hsum_next = clear_all ? '0 : (in_gesture ? s_dir : hsum);
    vtot_next = clear_all ? '0 : vt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_length      <= TARGET_LENGTH_RESET;
      vertical_tolerance <= VERTICAL_TOLERANCE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TARGET_LENGTH:      target_length      <= cfg_data;
        CFG_VERTICAL_TOLERANCE: vertical_tolerance <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hsum     <= '0;
      vtot     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (pop) begin
        hsum     <= hsum_next;
        vtot     <= vtot_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result.left_button    <= head.left_button;
      result.right_button   <= head.right_button;
      result.middle_button  <= head.middle_button;
      result.horiz_overflow <= head.horiz_overflow;
      result.vert_overflow  <= head.vert_overflow;
      result.delta_x        <= head.delta_x;
      result.delta_y        <= head.delta_y;
      result.travel_sum     <= tsum;
      result.gesture_done   <= done;
    end
  end

  a_done_clears_totals: assert property (@(posedge clk) disable iff (rst)
    (pop && done) |=> (hsum == '0) && (vtot == '0))
    else $error("totals not cleared after gesture");

  a_release_clears_totals: assert property (@(posedge clk) disable iff (rst)
    (pop && !head.left_button) |=> (hsum == '0) && (vtot == '0))
    else $error("totals not cleared on button release");

  a_pop_loads_output: assert property (@(posedge clk) disable iff (rst)
    pop |=> m_tvalid)
    else $error("popped packet produced no result");

endmodule

// File: rtl/core/mouse_gesture_detector_top.sv
// ----------------------------------------------------------------------------
// mouse_gesture_detector_top
// Frames PS/2 mouse bytes into packets and tracks a horizontal swipe gesture.
// ----------------------------------------------------------------------------
// One mouse byte is taken per cycle. Every third byte after a sync byte
// (bit 3 set) completes a packet; the framer pushes it into a short queue
// and the tracker loads its result into the output register once that register is free.
// The tracker updates both gesture totals as it pops each packet, so it
// retires one packet per cycle while the output register is free; a stalled
// output fills the queue and then holds off only the byte that completes a
// packet. Configuration writes take effect at the next cycle.
module mouse_gesture_detector_top #(
  parameter int QUEUE_DEPTH = mgd_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [mgd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mgd_pkg::CFG_W-1:0]       cfg_data,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [mgd_pkg::BYTE_W-1:0]      s_tdata,   // [7:0] mouse_byte
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [0] left_button, [1] right_button, [2] middle_button, [3] horiz_overflow,
  // [4] vert_overflow, [13:5] delta_x, [22:14] delta_y, [38:23] travel_sum,
  // [39] gesture_done
  output logic [mgd_pkg::RESULT_W-1:0]    m_tdata
);
  import mgd_pkg::*;

  queue_port_t push;
  logic        queue_full;
  logic        head_valid;
  packet_t     head;
  logic        pop;
  result_t     result;

  mgd_framer u_framer (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .queue_full (queue_full),
    .push       (push)
  );

  mgd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (queue_full),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  mgd_tracker u_tracker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .result     (result)
  );

  assign m_tdata = result;

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the mouse gesture detector. A short table of
// directed bytes covers sync hunting, field extremes and the tolerance edge,
// then phases of random packets under several target and tolerance settings
// drive the gesture sums into saturation. Every report is checked field by
// field against its typed table row or a bench model of framer and tracker.
// ----------------------------------------------------------------------------
module tb_top;
  import mgd_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_OFF   = 300;

  typedef enum int {DX_ANY, DX_RIGHT, DX_LEFT} dx_kind_t;
  typedef enum int {DY_SMALL, DY_DOWN_MAX, DY_ANY} dy_kind_t;

  typedef struct packed {
    logic [BYTE_W-1:0] mbyte;
    logic              typed;
    result_t           want;
  } byte_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_TARGET_LENGTH;
  logic [CFG_W-1:0]       cfg_data = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [BYTE_W-1:0]      s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [RESULT_W-1:0]    m_tdata;

  logic    row_typed = 1'b0;
  result_t row_want = '0;

  // bench copy of the block state
  logic [1:0]        frame_pos = 2'd0;
  logic [BYTE_W-1:0] head_byte = '0;
  logic [BYTE_W-1:0] dx_byte = '0;
  shortint           swipe_sum = 0;
  shortint unsigned  drift_total = 0;
  shortint           cfg_target = 100;
  shortint unsigned  cfg_tolerance = 10;

  result_t   pending_reports[$];
  byte_row_t directed_rows[$];
  int        mismatch_count = 0;
  int        idle_cycles = 0;
  bit        no_idle = 1'b0;
  int        hold_reqs = 0;
  int        hold_seen = 0;
  int        stall_left = 0;

  mouse_gesture_detector_top dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic result_t want_of(input bit lb, input bit rb, input bit mb,
                                      input bit xo, input bit yo,
                                      input logic [DELTA_W-1:0] dx,
                                      input logic [DELTA_W-1:0] dy,
                                      input logic [TOTAL_W-1:0] sum,
                                      input bit done);
    result_t w;
    w = '0;
    w.left_button = lb;
    w.right_button = rb;
    w.middle_button = mb;
    w.horiz_overflow = xo;
    w.vert_overflow = yo;
    w.delta_x = dx;
    w.delta_y = dy;
    w.travel_sum = sum;
    w.gesture_done = done;
    return w;
  endfunction

  // Frame one byte; on a completed packet, update the swipe tracker.
  function automatic bit frame_and_track(input logic [BYTE_W-1:0] b, output result_t r);
    int          dx;
    int          dy;
    int          s;
    int          seen_sum;
    int          vt;
    bit          left;
    bit          done;
    r = '0;
    if (frame_pos == 2'd1) begin
      dx_byte = b;
      frame_pos = 2'd2;
      return 1'b0;
    end
    if (frame_pos != 2'd2) begin
      if (b[SYNC_BIT]) begin
        head_byte = b;
        frame_pos = 2'd1;
      end else begin
        frame_pos = 2'd0;
      end
      return 1'b0;
    end
    frame_pos = 2'd0;
    left = head_byte[0];
    dx = head_byte[X_SIGN_BIT] ? int'(dx_byte) - 256 : int'(dx_byte);
    dy = head_byte[Y_SIGN_BIT] ? int'(b) - 256 : int'(b);
    vt = int'(drift_total) + (dy < 0 ? -dy : dy);
    if (vt > 65535) vt = 65535;
    drift_total = 16'(vt);
    seen_sum = int'(swipe_sum);
    done = 1'b0;
    if (drift_total < cfg_tolerance && left) begin
      s = int'(swipe_sum) + dx;
      if (s > 32767) s = 32767;
      if (s < -32768) s = -32768;
      seen_sum = s;
      if (cfg_target > 0) begin
        if (dx < 0) s = 0;
        if (s >= int'(cfg_target)) done = 1'b1;
      end else begin
        if (dx > 0) s = 0;
        if (s < int'(cfg_target)) done = 1'b1;
      end
      swipe_sum = 16'(s);
    end
    if (done || drift_total > cfg_tolerance || !left) begin
      swipe_sum = 0;
      drift_total = 0;
    end
    r = want_of(left, head_byte[1], head_byte[2], head_byte[6], head_byte[7],
                9'(dx), 9'(dy), 16'(seen_sum), done);
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : report_check
    result_t want;
    result_t got;
    result_t fresh;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (pending_reports.size() == 0) begin
          $error("unexpected report 0x%0h", m_tdata);
          mismatch_count++;
        end else begin
          want = pending_reports.pop_front();
          check_field("left_button", want.left_button, got.left_button);
          check_field("right_button", want.right_button, got.right_button);
          check_field("middle_button", want.middle_button, got.middle_button);
          check_field("horiz_overflow", want.horiz_overflow, got.horiz_overflow);
          check_field("vert_overflow", want.vert_overflow, got.vert_overflow);
          check_field("delta_x", want.delta_x, got.delta_x);
          check_field("delta_y", want.delta_y, got.delta_y);
          check_field("travel_sum", want.travel_sum, got.travel_sum);
          check_field("gesture_done", want.gesture_done, got.gesture_done);
        end
      end
      if (s_tvalid && s_tready) begin
        if (frame_and_track(s_tdata, fresh))
          pending_reports.push_back(row_typed ? row_want : fresh);
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // receiver: random back-pressure plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        stall_left = HOLD_OFF;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= no_idle || ($urandom_range(99) >= 34);
      end
    end
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b, input bit typed,
                           input result_t want);
    while (!no_idle && $urandom_range(99) < 34) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= b;
    row_typed <= typed;
    row_want <= want;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain_reports();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_gesture(input shortint target, input shortint unsigned tol);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_TARGET_LENGTH;
    cfg_data <= target;
    @(negedge clk);
    cfg_index <= CFG_VERTICAL_TOLERANCE;
    cfg_data <= tol;
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_target = target;
    cfg_tolerance = tol;
  endtask

  task automatic run_phase(input shortint target, input shortint unsigned tol,
                           input int packets, input int left_pct,
                           input dx_kind_t dxk, input dy_kind_t dyk,
                           input int noise_pct, input bit steady,
                           input bit hold_off);
    logic [BYTE_W-1:0] head;
    logic [BYTE_W-1:0] xb;
    logic [BYTE_W-1:0] yb;
    int                n;
    drain_reports();
    set_gesture(target, tol);
    no_idle = steady;
    for (int p = 0; p < packets; p++) begin
      if (hold_off && p == 10) hold_reqs++;
      if ($urandom_range(99) < noise_pct) begin
        n = $urandom_range(3, 1);
        repeat (n) send_byte(8'($urandom), 1'b0, '0);
      end
      head = 8'($urandom);
      head[SYNC_BIT] = 1'b1;
      head[0] = ($urandom_range(99) < left_pct);
      case (dxk)
        DX_RIGHT: begin
          head[X_SIGN_BIT] = 1'b0;
          xb = 8'($urandom_range(255, 230));
        end
        DX_LEFT: begin
          head[X_SIGN_BIT] = 1'b1;
          xb = 8'($urandom_range(40, 0));
        end
        default: xb = 8'($urandom);
      endcase
      case (dyk)
        DY_SMALL: begin
          yb = head[Y_SIGN_BIT] ? 8'($urandom_range(255, 250)) : 8'($urandom_range(5, 0));
        end
        DY_DOWN_MAX: begin
          head[Y_SIGN_BIT] = 1'b1;
          yb = '0;
        end
        default: yb = 8'($urandom);
      endcase
      send_byte(head, 1'b0, '0);
      send_byte(xb, 1'b0, '0);
      send_byte(yb, 1'b0, '0);
    end
    no_idle = 1'b0;
  endtask

  initial begin
    // dropped bytes, then packets from reset state
    directed_rows.push_back({8'h00, 1'b0, result_t'('0)});
    directed_rows.push_back({8'hF7, 1'b0, result_t'('0)});
    directed_rows.push_back({8'h08, 1'b0, result_t'('0)});
    directed_rows.push_back({8'h00, 1'b0, result_t'('0)});
    directed_rows.push_back({8'h00, 1'b1, result_t'('0)});
    directed_rows.push_back({8'hFF, 1'b0, result_t'('0)});
    directed_rows.push_back({8'hFF, 1'b0, result_t'('0)});
    directed_rows.push_back({8'hFF, 1'b1,
      want_of(1, 1, 1, 1, 1, 9'h1FF, 9'h1FF, 16'hFFFF, 0)});
    directed_rows.push_back({8'h09, 1'b0, result_t'('0)});
    directed_rows.push_back({8'h7F, 1'b0, result_t'('0)});
    directed_rows.push_back({8'h00, 1'b1,
      want_of(1, 0, 0, 0, 0, 9'h07F, 9'h000, 16'd127, 1)});
    directed_rows.push_back({8'h29, 1'b0, result_t'('0)});
    directed_rows.push_back({8'h00, 1'b0, result_t'('0)});
    directed_rows.push_back({8'h00, 1'b1,
      want_of(1, 0, 0, 0, 0, 9'h000, 9'h100, 16'd0, 0)});
    directed_rows.push_back({8'h19, 1'b0, result_t'('0)});
    directed_rows.push_back({8'h00, 1'b0, result_t'('0)});
    directed_rows.push_back({8'h00, 1'b1,
      want_of(1, 0, 0, 0, 0, 9'h100, 9'h000, 16'hFF00, 0)});
    // vertical total lands exactly on the tolerance
    directed_rows.push_back({8'h09, 1'b0, result_t'('0)});
    directed_rows.push_back({8'h05, 1'b0, result_t'('0)});
    directed_rows.push_back({8'h0A, 1'b0, result_t'('0)});
    directed_rows.push_back({8'h09, 1'b0, result_t'('0)});
    directed_rows.push_back({8'h05, 1'b0, result_t'('0)});
    directed_rows.push_back({8'h00, 1'b0, result_t'('0)});

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_byte(directed_rows[i].mbyte, directed_rows[i].typed, directed_rows[i].want);

    run_phase(100, 10, 30, 80, DX_ANY, DY_SMALL, 8, 1'b0, 1'b1);
    run_phase(0, 65535, 30, 80, DX_ANY, DY_ANY, 8, 1'b0, 1'b0);
    run_phase(32767, 65535, 150, 100, DX_RIGHT, DY_SMALL, 0, 1'b1, 1'b0);
    run_phase(-32768, 65535, 260, 100, DX_LEFT, DY_DOWN_MAX, 0, 1'b0, 1'b0);
    run_phase(-50, 200, 30, 70, DX_ANY, DY_SMALL, 8, 1'b0, 1'b0);
    run_phase(1, 0, 30, 80, DX_ANY, DY_SMALL, 8, 1'b0, 1'b0);
    run_phase(300, 1000, 30, 90, DX_ANY, DY_ANY, 8, 1'b0, 1'b0);
    run_phase(100, 10, 30, 80, DX_ANY, DY_ANY, 8, 1'b0, 1'b0);
    drain_reports();

    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: mouse_gesture_detector_top.f
rtl/core/mgd_pkg.sv
rtl/core/mgd_framer.sv
rtl/core/mgd_queue.sv
rtl/core/mgd_tracker.sv
rtl/core/mouse_gesture_detector_top.sv
bench/tb_top.sv
